FILE: rtl/hwrgb_pkg.sv
// Shared types and constants for the hue wheel to RGB dimmer.
`default_nettype none

package hwrgb_pkg;

   localparam int unsigned HUE_W      = 8;
   localparam int unsigned LEVEL_W    = 8;
   localparam int unsigned WIDE_W     = 16;
   localparam int unsigned CSR_DATA_W = 8;

   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [WIDE_W-1:0]  wide_type;

   // One color sample, one level per channel
   typedef struct packed {
      level_type red;
      level_type green;
      level_type blue;
   } rgb_type;

   // The same sample widened for a 16-bit PWM driver
   typedef struct packed {
      wide_type red;
      wide_type green;
      wide_type blue;
   } rgb_wide_type;

   // Register map of the CSR write channel
   typedef enum logic [0:0] {
      CSR_BRIGHTNESS = 1'b0,
      CSR_LED_ON     = 1'b1
   } csr_index_type;

   localparam level_type BRIGHTNESS_RESET = 8'd255;
   localparam logic      LED_ON_RESET     = 1'b1;
   localparam level_type LEVEL_FULL       = 8'd255;
   localparam level_type LEVEL_ZERO       = 8'd0;

   // Last hue of each wheel segment but the final one
   localparam logic [HUE_W-1:0] SEG0_END = 8'd41;
   localparam logic [HUE_W-1:0] SEG1_END = 8'd84;
   localparam logic [HUE_W-1:0] SEG2_END = 8'd126;
   localparam logic [HUE_W-1:0] SEG3_END = 8'd169;
   localparam logic [HUE_W-1:0] SEG4_END = 8'd211;

   // First hue of each wheel segment after the first
   localparam logic [HUE_W-1:0] SEG1_BASE = 8'd42;
   localparam logic [HUE_W-1:0] SEG2_BASE = 8'd85;
   localparam logic [HUE_W-1:0] SEG3_BASE = 8'd127;
   localparam logic [HUE_W-1:0] SEG4_BASE = 8'd170;
   localparam logic [HUE_W-1:0] SEG5_BASE = 8'd212;

   // Ramp division: offset*255/span as (offset*255*RECIP) >> RECIP_SHIFT.
   // RECIP = ceil(2^20/span); the rounding error times the largest
   // numerator stays below 2^20, so the quotient is exact.
   localparam int unsigned OFFSET_W    = 6;
   localparam int unsigned NUMER_W     = 14;
   localparam int unsigned RECIP_W     = 15;
   localparam int unsigned RECIP_SHIFT = 20;
   localparam int unsigned PRODUCT_W   = NUMER_W + RECIP_W;

   localparam logic [RECIP_W-1:0] RECIP_41 = 15'd25576;
   localparam logic [RECIP_W-1:0] RECIP_42 = 15'd24967;
   localparam logic [RECIP_W-1:0] RECIP_43 = 15'd24386;

endpackage

`default_nettype wire

FILE: rtl/hwrgb_wheel.sv
// Six-segment color wheel: hue to unscaled red, green and blue levels.
`default_nettype none

module hwrgb_wheel (
   input  logic [hwrgb_pkg::HUE_W-1:0] hue,
   output hwrgb_pkg::rgb_type           color
);
   import hwrgb_pkg::*;

   typedef enum logic [5:0] {
      SEG_RED_GREEN_UP  = 6'b000001,
      SEG_RED_DOWN      = 6'b000010,
      SEG_BLUE_UP       = 6'b000100,
      SEG_GREEN_DOWN    = 6'b001000,
      SEG_RED_UP        = 6'b010000,
      SEG_BLUE_DOWN     = 6'b100000
   } seg_type;

   seg_type                segment;
   logic [OFFSET_W-1:0]    offset;
   logic [RECIP_W-1:0]     recip;
   logic                   falling;
   logic [NUMER_W-1:0]     numer;
   logic [PRODUCT_W-1:0]   product;
   level_type              quotient;
   level_type              ramp;

   // Pick the segment, the offset into it and the span reciprocal
   always_comb begin
      priority if (hue <= SEG0_END) begin
         segment = SEG_RED_GREEN_UP;
         offset  = hue[OFFSET_W-1:0];
         recip   = RECIP_41;
         falling = 1'b0;
      end else if (hue <= SEG1_END) begin
         segment = SEG_RED_DOWN;
         offset  = OFFSET_W'(hue - SEG1_BASE);
         recip   = RECIP_42;
         falling = 1'b1;
      end else if (hue <= SEG2_END) begin
         segment = SEG_BLUE_UP;
         offset  = OFFSET_W'(hue - SEG2_BASE);
         recip   = RECIP_41;
         falling = 1'b0;
      end else if (hue <= SEG3_END) begin
         segment = SEG_GREEN_DOWN;
         offset  = OFFSET_W'(hue - SEG3_BASE);
         recip   = RECIP_42;
         falling = 1'b1;
      end else if (hue <= SEG4_END) begin
         segment = SEG_RED_UP;
         offset  = OFFSET_W'(hue - SEG4_BASE);
         recip   = RECIP_41;
         falling = 1'b0;
      end else begin
         segment = SEG_BLUE_DOWN;
         offset  = OFFSET_W'(hue - SEG5_BASE);
         recip   = RECIP_43;
         falling = 1'b1;
      end
   end

   // Ramp = offset*255/span, truncated; a falling ramp is 255 minus that
   assign numer    = {offset, 8'h00} - NUMER_W'(offset);
   assign product  = PRODUCT_W'(numer) * PRODUCT_W'(recip);
   assign quotient = product[RECIP_SHIFT +: LEVEL_W];
   assign ramp     = falling ? ~quotient : quotient;

   // Place the ramp and the held channels
   always_comb begin
      unique case (segment)
         SEG_RED_GREEN_UP: begin
            color = '{red: LEVEL_FULL, green: ramp, blue: LEVEL_ZERO};
         end
         SEG_RED_DOWN: begin
            color = '{red: ramp, green: LEVEL_FULL, blue: LEVEL_ZERO};
         end
         SEG_BLUE_UP: begin
            color = '{red: LEVEL_ZERO, green: LEVEL_FULL, blue: ramp};
         end
         SEG_GREEN_DOWN: begin
            color = '{red: LEVEL_ZERO, green: ramp, blue: LEVEL_FULL};
         end
         SEG_RED_UP: begin
            color = '{red: ramp, green: LEVEL_ZERO, blue: LEVEL_FULL};
         end
         SEG_BLUE_DOWN: begin
            color = '{red: LEVEL_FULL, green: LEVEL_ZERO, blue: ramp};
         end
         default: begin
            color = '{red: LEVEL_ZERO, green: LEVEL_ZERO, blue: LEVEL_ZERO};
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/hwrgb_scale.sv
// Brightness scaling of a color sample and widening to 16 bits.
`default_nettype none

module hwrgb_scale (
   input  hwrgb_pkg::rgb_type   color,
   input  hwrgb_pkg::level_type brightness,
   output hwrgb_pkg::rgb_type   level,
   output hwrgb_pkg::rgb_wide_type wide
);
   import hwrgb_pkg::*;

   // v*b/255, truncated; exact for products up to 65279
   function automatic level_type dim(input level_type v, input level_type b);
      logic [WIDE_W-1:0] p;
      logic [WIDE_W:0]   s;
      p = WIDE_W'(v) * WIDE_W'(b);
      s = (WIDE_W+1)'(p) + (WIDE_W+1)'(p[WIDE_W-1:LEVEL_W]) + (WIDE_W+1)'(1);
      return s[WIDE_W-1:LEVEL_W];
   endfunction

   // Scale each channel
   assign level.red   = dim(color.red, brightness);
   assign level.green = dim(color.green, brightness);
   assign level.blue  = dim(color.blue, brightness);

   // Widen as level*257: the level repeated in both bytes
   assign wide.red   = {level.red, level.red};
   assign wide.green = {level.green, level.green};
   assign wide.blue  = {level.blue, level.blue};

endmodule

`default_nettype wire

FILE: rtl/hue_wheel_to_rgb_dimmer_core.sv
// Top level: hue in, dimmed RGB levels and 16-bit driver values out.
//
//   channel  ports                    direction  contents
//   req      req_valid/req_stall      in         hue
//   rsp      rsp_valid/rsp_stall      out        three levels, three wide values, enable
//   csr      csr_valid/csr_ready      in         register index and write data
//
// One word per cycle while rsp is not stalled; a word passes through the hue
// register, the wheel register and the result register in that order, with
// the ramp multiplier and the brightness multipliers each closing a stage.
// Each stage advances when it is empty or the stage after it advances, so
// a stall on rsp fills the pipe before req_stall rises.
// Reset clears the valid bits and sets brightness to 255 and led_on to 1.
// csr_ready is always high.
`default_nettype none

module hue_wheel_to_rgb_dimmer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [hwrgb_pkg::HUE_W-1:0]          req_hue,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output hwrgb_pkg::level_type                 rsp_red_level,
   output hwrgb_pkg::level_type                 rsp_green_level,
   output hwrgb_pkg::level_type                 rsp_blue_level,
   output hwrgb_pkg::wide_type                  rsp_red_wide,
   output hwrgb_pkg::wide_type                  rsp_green_wide,
   output hwrgb_pkg::wide_type                  rsp_blue_wide,
   output logic                                 rsp_drive_enable,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  hwrgb_pkg::csr_index_type             csr_index,
   input  logic [hwrgb_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import hwrgb_pkg::*;

   level_type         brightness_ff, brightness_in;
   logic              led_on_ff, led_on_in;

   logic              s1_valid_ff, s1_valid_in;
   logic [HUE_W-1:0]  s1_hue_ff;
   logic              s2_valid_ff, s2_valid_in;
   rgb_type           s2_color_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rgb_type           rsp_level_ff;
   rgb_wide_type      rsp_wide_ff;
   logic              rsp_enable_ff;

   logic              out_open, s2_open, s1_open;
   logic              s1_load, s2_load, out_load;
   rgb_type           wheel_color;
   rgb_type           scaled_level;
   rgb_wide_type      scaled_wide;

   // Register writes
   assign csr_ready = 1'b1;

   always_comb begin
      brightness_in = brightness_ff;
      led_on_in     = led_on_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BRIGHTNESS: brightness_in = csr_wdata;
            CSR_LED_ON:     led_on_in     = csr_wdata[0];
            default:        brightness_in = brightness_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHTNESS_RESET;
         led_on_ff     <= LED_ON_RESET;
      end else begin
         brightness_ff <= brightness_in;
         led_on_ff     <= led_on_in;
      end
   end

   // Stage flow: advance into a stage that is empty or draining
   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign s2_open   = !s2_valid_ff || out_open;
   assign s1_open   = !s1_valid_ff || s2_open;
   assign req_stall = !s1_open;

   assign s1_load  = req_valid && s1_open;
   assign s2_load  = s1_valid_ff && s2_open;
   assign out_load = s2_valid_ff && out_open;

   assign s1_valid_in  = s1_load || (s1_valid_ff && !s2_open);
   assign s2_valid_in  = s2_load || (s2_valid_ff && !out_open);
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Wheel stage
   hwrgb_wheel u_wheel (
      .hue   (s1_hue_ff),
      .color (wheel_color)
   );

   // Brightness stage
   hwrgb_scale u_scale (
      .color      (s2_color_ff),
      .brightness (brightness_ff),
      .level      (scaled_level),
      .wide       (scaled_wide)
   );

   // Payload registers: load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_hue_ff <= req_hue;
      end
      if (s2_load) begin
         s2_color_ff <= wheel_color;
      end
      if (out_load) begin
         rsp_level_ff  <= scaled_level;
         rsp_wide_ff   <= scaled_wide;
         rsp_enable_ff <= led_on_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red_level    = rsp_level_ff.red;
   assign rsp_green_level  = rsp_level_ff.green;
   assign rsp_blue_level   = rsp_level_ff.blue;
   assign rsp_red_wide     = rsp_wide_ff.red;
   assign rsp_green_wide   = rsp_wide_ff.green;
   assign rsp_blue_wide    = rsp_wide_ff.blue;
   assign rsp_drive_enable = rsp_enable_ff;

endmodule

`default_nettype wire

FILE: rtl/hwrgb_checker.sv
// Port-level checks for the dimmer core, bound to the top level.
`default_nettype none

module hwrgb_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_stall,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  hwrgb_pkg::level_type    rsp_red_level,
   input  hwrgb_pkg::level_type    rsp_green_level,
   input  hwrgb_pkg::level_type    rsp_blue_level,
   input  hwrgb_pkg::wide_type     rsp_red_wide,
   input  hwrgb_pkg::wide_type     rsp_green_wide,
   input  hwrgb_pkg::wide_type     rsp_blue_wide,
   input  logic                    rsp_drive_enable
);
   import hwrgb_pkg::*;

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A stalled word stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // A stalled word does not change
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_red_level) && $stable(rsp_green_level)
         && $stable(rsp_blue_level) && $stable(rsp_drive_enable))
      else $error("rsp word changed while stalled");

   // Wide values are the levels times 257
   a_wide_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_red_wide == {rsp_red_level, rsp_red_level}
         && rsp_green_wide == {rsp_green_level, rsp_green_level}
         && rsp_blue_wide == {rsp_blue_level, rsp_blue_level})
      else $error("wide value does not match level");

   // With the result register empty the input side never stalls
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled with empty result register");

endmodule

bind hue_wheel_to_rgb_dimmer_core hwrgb_checker u_hwrgb_checker (.*);

`default_nettype wire

FILE: test/tb.sv
// Self-checking bench for the hue wheel to RGB dimmer core.
module tb;
   import hwrgb_pkg::*;

   localparam int CLOCK_PERIOD   = 12;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int HOLD_CYCLES    = 80;
   localparam int FLUSH_CYCLES   = 10;
   localparam int PHASE_ITEMS    = 105;
   localparam int PHASE_COUNT    = 9;
   localparam int MAX_PRINTS     = 100;

   // Wheel segment bounds
   localparam int unsigned SEG_A_LAST = 41;
   localparam int unsigned SEG_B_LAST = 84;
   localparam int unsigned SEG_C_LAST = 126;
   localparam int unsigned SEG_D_LAST = 169;
   localparam int unsigned SEG_E_LAST = 211;

   // Hues on both sides of every segment boundary
   localparam logic [7:0] WHEEL_EDGES [12] = '{
      8'd0, 8'd41, 8'd42, 8'd84, 8'd85, 8'd126,
      8'd127, 8'd169, 8'd170, 8'd211, 8'd212, 8'd255
   };

   typedef struct packed {
      rgb_type      level;
      rgb_wide_type wide;
      logic         enable;
   } color_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [HUE_W-1:0]  req_hue = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   level_type         rsp_red_level, rsp_green_level, rsp_blue_level;
   wide_type          rsp_red_wide, rsp_green_wide, rsp_blue_wide;
   logic              rsp_drive_enable;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   csr_index_type     csr_index = CSR_BRIGHTNESS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the block's registers
   level_type         dim_level = BRIGHTNESS_RESET;
   logic              led_enable = LED_ON_RESET;

   logic [HUE_W-1:0]  hue_backlog [$];
   color_word_type    expected_colors [$];
   int                hues_offered = 0;
   int                hues_taken = 0;
   int                error_count = 0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   int                hold_request = 0;
   int                hold_seen = 0;
   int                hold_left = 0;

   hue_wheel_to_rgb_dimmer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_hue          (req_hue),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_level    (rsp_red_level),
      .rsp_green_level  (rsp_green_level),
      .rsp_blue_level   (rsp_blue_level),
      .rsp_red_wide     (rsp_red_wide),
      .rsp_green_wide   (rsp_green_wide),
      .rsp_blue_wide    (rsp_blue_wide),
      .rsp_drive_enable (rsp_drive_enable),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Map a hue onto the wheel, dim it and widen it
   function automatic color_word_type wheel_color(logic [HUE_W-1:0] hue_in);
      int unsigned    h, r, g, b;
      color_word_type w;
      h = hue_in;
      if (h <= SEG_A_LAST) begin
         r = 255; g = h * 255 / 41; b = 0;
      end else if (h <= SEG_B_LAST) begin
         r = 255 - (h - 42) * 255 / 42; g = 255; b = 0;
      end else if (h <= SEG_C_LAST) begin
         r = 0; g = 255; b = (h - 85) * 255 / 41;
      end else if (h <= SEG_D_LAST) begin
         r = 0; g = 255 - (h - 127) * 255 / 42; b = 255;
      end else if (h <= SEG_E_LAST) begin
         r = (h - 170) * 255 / 41; g = 0; b = 255;
      end else begin
         r = 255; g = 0; b = 255 - (h - 212) * 255 / 43;
      end
      w.level.red   = level_type'(r * dim_level / 255);
      w.level.green = level_type'(g * dim_level / 255);
      w.level.blue  = level_type'(b * dim_level / 255);
      w.wide.red    = wide_type'(w.level.red * 257);
      w.wide.green  = wide_type'(w.level.green * 257);
      w.wide.blue   = wide_type'(w.level.blue * 257);
      w.enable      = led_enable;
      return w;
   endfunction

   task automatic report_mismatch(string msg);
      if (error_count < MAX_PRINTS)
         $display("tb: mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Offer the next hue from the backlog; hold a word until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && hues_offered != hues_taken) begin
         // hold the stalled word
      end else if (hue_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         req_valid <= 1'b1;
         req_hue   <= hue_backlog.pop_front();
         hues_offered++;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Stall the result channel at random, or for a long stretch on request
   always @(negedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen = hold_request;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Check each result word, then record each accepted hue
   always @(posedge clock) begin
      color_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_colors.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            want = expected_colors.pop_front();
            if (rsp_red_level != want.level.red)
               report_mismatch($sformatf("red_level %0d, want %0d",
                                         rsp_red_level, want.level.red));
            if (rsp_green_level != want.level.green)
               report_mismatch($sformatf("green_level %0d, want %0d",
                                         rsp_green_level, want.level.green));
            if (rsp_blue_level != want.level.blue)
               report_mismatch($sformatf("blue_level %0d, want %0d",
                                         rsp_blue_level, want.level.blue));
            if (rsp_red_wide != want.wide.red)
               report_mismatch($sformatf("red_wide %0d, want %0d",
                                         rsp_red_wide, want.wide.red));
            if (rsp_green_wide != want.wide.green)
               report_mismatch($sformatf("green_wide %0d, want %0d",
                                         rsp_green_wide, want.wide.green));
            if (rsp_blue_wide != want.wide.blue)
               report_mismatch($sformatf("blue_wide %0d, want %0d",
                                         rsp_blue_wide, want.wide.blue));
            if (rsp_drive_enable !== want.enable)
               report_mismatch($sformatf("drive_enable %0b, want %0b",
                                         rsp_drive_enable, want.enable));
         end
      end
      if (!reset && req_valid && !req_stall) begin
         expected_colors.push_back(wheel_color(req_hue));
         hues_taken++;
      end
   end

   // Write one register and mirror it in the shadow copy
   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BRIGHTNESS: dim_level  = data;
         CSR_LED_ON:     led_enable = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_led(logic on);
      write_register(CSR_LED_ON, {7'($urandom), on});
   endtask

   // Wait until every queued hue is taken and every result has come
   task automatic wait_drained();
      while (hue_backlog.size() != 0 || hues_offered != hues_taken ||
             expected_colors.size() != 0)
         @(posedge clock);
   endtask

   task automatic queue_random_hues(int count);
      repeat (count) begin
         if ($urandom_range(7) == 0)
            hue_backlog.push_back(WHEEL_EDGES[$urandom_range(11)]);
         else
            hue_backlog.push_back(HUE_W'($urandom_range(255)));
      end
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
   endtask

   // End the run if it hangs
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("tb: failure");
      $finish;
   end

   initial begin
      level_type bright_pick [PHASE_COUNT];
      bright_pick = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd254, 8'd0, 8'd0, 8'd0, 8'd0};
      for (int i = 5; i < PHASE_COUNT; i++)
         bright_pick[i] = level_type'($urandom_range(255));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every segment edge and alternating bits at reset settings
      set_idling(10, 75);
      foreach (WHEEL_EDGES[i])
         hue_backlog.push_back(WHEEL_EDGES[i]);
      hue_backlog.push_back(8'h55);
      hue_backlog.push_back(8'hAA);
      hue_backlog.push_back(8'd1);
      wait_drained();

      // Directed: zero brightness with the LED off
      write_register(CSR_BRIGHTNESS, 8'd0);
      set_led(1'b0);
      hue_backlog.push_back(8'd0);
      hue_backlog.push_back(8'd127);
      hue_backlog.push_back(8'd200);
      hue_backlog.push_back(8'd255);
      wait_drained();

      // Directed: lowest nonzero brightness with the LED on
      write_register(CSR_BRIGHTNESS, 8'd1);
      set_led(1'b1);
      hue_backlog.push_back(8'd0);
      hue_backlog.push_back(8'd42);
      hue_backlog.push_back(8'd170);
      wait_drained();

      // Back-pressure: hold results off while the sender keeps offering
      write_register(CSR_BRIGHTNESS, 8'd200);
      set_idling(0, 0);
      hold_request++;
      queue_random_hues(40);
      wait_drained();

      // Random phases over several register settings and idling patterns
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p / 3)
            0: set_idling(10, 75);
            1: set_idling(75, 10);
            default: set_idling(0, 0);
         endcase
         write_register(CSR_BRIGHTNESS, bright_pick[p]);
         set_led(p[0]);
         queue_random_hues(PHASE_ITEMS);
         wait_drained();
      end

      repeat (FLUSH_CYCLES) @(posedge clock);
      if (expected_colors.size() != 0)
         report_mismatch("results still expected at the end");
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
